[rtl/core/base85_stream_codec_defines.svh]
// Assertion macros shared by the base85 stream codec RTL.
`ifndef BASE85_STREAM_CODEC_DEFINES_SVH
`define BASE85_STREAM_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property at every rising edge, skipped while reset is high.
`define BSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check a property at every rising edge, reset included.
`define BSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define BSC_ASSERT(lbl, clk, rst, prop)
`define BSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/core/bsc_pkg.sv]
// Types, constants and helper functions of the base85 stream codec.
package bsc_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int RADIX_N    = 85;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET  = 2'd1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;
   localparam logic ALPHA_Z85  = 1'b0;
   localparam logic ALPHA_A85  = 1'b1;

   // group sizes: bytes per encode group, characters per decode group
   localparam logic [2:0] ENC_GROUP = 3'd4;
   localparam logic [2:0] DEC_GROUP = 3'd5;
   localparam logic [2:0] ENC_CHARS = 3'd5;
   localparam logic [2:0] DEC_BYTES = 3'd4;
   localparam logic [2:0] DIV_STEPS = 3'd4;

   localparam logic [6:0] LAST_DIGIT = 7'd84;
   localparam logic [7:0] A85_FIRST  = 8'd33;
   localparam logic [7:0] A85_LAST   = 8'd117;

   // floor(v / 85) == (v * RECIP_85) >> RECIP_SHIFT for every 32-bit v
   localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
   localparam int          RECIP_SHIFT = 38;

   localparam logic [0:RADIX_N-1][7:0] Z85_SET =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  count;
      logic        last;
      logic        decode;
      logic        alpha;
   } job_type;

   typedef struct packed {
      logic [0:4][7:0] data;
      logic [2:0]      count;
      logic            last;
   } group_type;

   function automatic logic [31:0] times85(input logic [31:0] v);
      return (v << 6) + (v << 4) + (v << 2) + v;
   endfunction

   function automatic logic [7:0] times85_lo(input logic [7:0] x);
      return (x << 6) + (x << 4) + (x << 2) + x;
   endfunction

   // Unknown characters map to digit 0.
   function automatic logic [6:0] char_to_digit(input logic [7:0] c, input logic alpha);
      logic [6:0] d;
      logic [7:0] off;
      d   = '0;
      off = c - A85_FIRST;
      if (alpha == ALPHA_A85) begin
         if (c >= A85_FIRST && c <= A85_LAST) begin
            d = off[6:0];
         end
      end else begin
         for (int i = 0; i < RADIX_N; i++) begin
            if (Z85_SET[i] == c) begin
               d = 7'(i);
            end
         end
      end
      return d;
   endfunction

   function automatic logic [7:0] digit_to_char(input logic [6:0] d, input logic alpha);
      logic [7:0] c;
      if (alpha == ALPHA_A85) begin
         c = A85_FIRST + {1'b0, d};
      end else begin
         c = Z85_SET[d];
      end
      return c;
   endfunction

endpackage

[rtl/core/bsc_if.sv]
// Channel interfaces of the base85 stream codec: input, result and register write.
interface bsc_req_if;
   import bsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface bsc_rsp_if;
   import bsc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   modport source (output valid, out_byte, out_last, input ready);
   modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface bsc_csr_if;
   import bsc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  wr_index;
   logic [CSR_DATA_W-1:0] wr_data;
   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

[rtl/core/bsc_front.sv]
// Front end: register file, item intake and group assembly.
module bsc_front (
   input  logic              clock,
   input  logic              reset,
   bsc_req_if.sink           req_ch,
   bsc_csr_if.sink           csr_ch,
   output logic              job_valid,
   input  logic              job_ready,
   output bsc_pkg::job_type  job
);
   import bsc_pkg::*;

   logic [31:0] value_ff;
   logic [2:0]  count_ff;
   logic        dir_ff;
   logic        alpha_ff;

   logic [31:0] value_in;
   logic [2:0]  count_in;
   logic [6:0]  digit;
   logic [4:0]  shamt;
   logic        accept;
   logic        complete;
   logic        empty_group;

   assign req_ch.ready = job_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && job_ready;

   always_comb begin
      count_in    = count_ff + 3'd1;
      digit       = char_to_digit(req_ch.in_byte, alpha_ff);
      shamt       = {~count_ff[1:0], 3'b000};
      if (dir_ff == DIR_DECODE) begin
         value_in = times85(value_ff) + {25'd0, digit};
         complete = (count_in == DEC_GROUP) || req_ch.in_last;
      end else begin
         value_in = value_ff | ({24'd0, req_ch.in_byte} << shamt);
         complete = (count_in == ENC_GROUP) || req_ch.in_last;
      end
      // a lone final character decodes to nothing
      empty_group = (dir_ff == DIR_DECODE) && (count_in == 3'd1);
   end

   assign job_valid  = accept && complete && !empty_group;
   assign job.value  = value_in;
   assign job.count  = count_in;
   assign job.last   = req_ch.in_last;
   assign job.decode = dir_ff;
   assign job.alpha  = alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         count_ff <= '0;
         dir_ff   <= DIR_ENCODE;
         alpha_ff <= ALPHA_Z85;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.wr_index)
            CSR_DIRECTION: begin
               dir_ff   <= csr_ch.wr_data[0];
               value_ff <= '0;
               count_ff <= '0;
            end
            CSR_ALPHABET: begin
               alpha_ff <= csr_ch.wr_data[0];
               value_ff <= '0;
               count_ff <= '0;
            end
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end else if (accept) begin
         if (complete) begin
            value_ff <= '0;
            count_ff <= '0;
         end else begin
            value_ff <= value_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

[rtl/core/bsc_queue.sv]
// Small job queue between the front end and the conversion engine.
`include "base85_stream_codec_defines.svh"

module bsc_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bsc_pkg::job_type  push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bsc_pkg::job_type  pop_job
);
   import bsc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `BSC_ASSERT(a_queue_bound, clock, reset, count_ff <= CNT_FULL)
   `BSC_ASSERT(a_queue_fill, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

[rtl/core/bsc_exec.sv]
// Conversion engine: digit extraction for encode, padding for decode.
`include "base85_stream_codec_defines.svh"

module bsc_exec (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  bsc_pkg::job_type    job,
   output logic                grp_valid,
   input  logic                grp_ready,
   output bsc_pkg::group_type  grp
);
   import bsc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_PAD, S_DONE} state_type;

   state_type       state_ff;
   logic [2:0]      step_ff;
   logic [31:0]     cur_ff;
   logic [0:4][7:0] lo_ff;
   logic            dec_ff;
   logic            alpha_ff;
   logic            last_ff;
   logic [2:0]      n_ff;

   logic            load;
   logic [63:0]     prod;
   logic [31:0]     div_in;
   logic [31:0]     pad_in;
   logic [2:0]      enc_n;
   logic [2:0]      dec_n;
   logic [2:0]      pad_n;
   logic [0:4][6:0] digit;
   logic [0:4][7:0] dec_bytes;

   assign job_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && grp_ready);
   assign load      = job_valid && job_ready;
   assign grp_valid = (state_ff == S_DONE);

   always_comb begin
      prod   = 64'(cur_ff) * 64'(RECIP_85);
      div_in = 32'(prod[63:RECIP_SHIFT]);
      pad_in = times85(cur_ff) + {25'd0, LAST_DIGIT};
      enc_n  = (job.count == ENC_GROUP) ? ENC_CHARS : job.count + 3'd1;
      dec_n  = (job.count == DEC_GROUP) ? DEC_BYTES : job.count - 3'd1;
      pad_n  = DEC_GROUP - job.count;
   end

   // lo_ff holds the low bytes of v, v/85, ..., v/85^4; each digit is
   // q[k] - 85*q[k+1], which fits in the low byte.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         digit[k] = 7'(lo_ff[k] - times85_lo(lo_ff[k+1]));
      end
      digit[4]  = lo_ff[4][6:0];
      dec_bytes = {cur_ff, 8'd0};
      for (int j = 0; j < 5; j++) begin
         grp.data[j] = dec_ff ? dec_bytes[j] : digit_to_char(digit[4-j], alpha_ff);
      end
      grp.count = n_ff;
      grp.last  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else if (load) begin
         cur_ff   <= job.value;
         lo_ff[4] <= job.value[7:0];
         dec_ff   <= job.decode;
         alpha_ff <= job.alpha;
         last_ff  <= job.last;
         if (job.decode) begin
            n_ff     <= dec_n;
            step_ff  <= pad_n;
            state_ff <= (pad_n == '0) ? S_DONE : S_PAD;
         end else begin
            n_ff     <= enc_n;
            step_ff  <= '0;
            state_ff <= S_DIV;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               // wait for a job
            end
            S_DIV: begin
               cur_ff     <= div_in;
               lo_ff[0:3] <= lo_ff[1:4];
               lo_ff[4]   <= div_in[7:0];
               step_ff    <= step_ff + 3'd1;
               if (step_ff == DIV_STEPS - 3'd1) begin
                  state_ff <= S_DONE;
               end
            end
            S_PAD: begin
               cur_ff  <= pad_in;
               step_ff <= step_ff - 3'd1;
               if (step_ff == 3'd1) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (grp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `BSC_ASSERT(a_pad_only_decode, clock, reset, (state_ff == S_PAD) |-> (dec_ff && step_ff != '0))
   `BSC_ASSERT(a_div_only_encode, clock, reset, (state_ff == S_DIV) |-> !dec_ff)

endmodule

[rtl/core/bsc_emit.sv]
// Result serializer: holds one converted group and hands it out a byte per transfer.
`include "base85_stream_codec_defines.svh"

module bsc_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                grp_valid,
   output logic                grp_ready,
   input  bsc_pkg::group_type  grp,
   bsc_rsp_if.source           rsp_ch
);
   import bsc_pkg::*;

   logic [0:4][7:0] data_ff;
   logic [2:0]      n_ff;
   logic [2:0]      idx_ff;
   logic            last_ff;
   logic            busy_ff;

   logic            at_end;
   logic            finish;
   logic            load;

   assign at_end    = (idx_ff == n_ff - 3'd1);
   assign finish    = busy_ff && rsp_ch.ready && at_end;
   assign grp_ready = !busy_ff || finish;
   assign load      = grp_valid && grp_ready;

   assign rsp_ch.valid    = busy_ff;
   assign rsp_ch.out_byte = data_ff[idx_ff];
   assign rsp_ch.out_last = last_ff && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         data_ff <= grp.data;
         n_ff    <= grp.count;
         last_ff <= grp.last;
         idx_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (finish) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && rsp_ch.ready) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   `BSC_ASSERT(a_emit_index, clock, reset, busy_ff |-> (n_ff != '0 && idx_ff < n_ff))

endmodule

[rtl/core/base85_stream_codec.sv]
// Top level of the base85 stream codec.
//
// Streaming Base85 codec, Z85 or Ascii85 alphabet. Each input transfer carries
// one byte and a last-of-message flag; each result transfer carries one byte
// and a flag that marks the final result of the message. Register 0 selects
// encode (0) or decode (1), register 1 selects Z85 (0) or Ascii85 (1); a write
// to either register drops any partial group, a write to any other index is
// ignored. Write registers only while no transfer is in flight. Encode packs
// four bytes big-endian and sends five characters, most significant first; a
// final group of r bytes sends r+1 characters. Decode packs five characters
// (unknown characters count as digit 0) and sends four bytes; a final group of
// r characters sends r-1 bytes, so a lone final character sends nothing.
// Rate: the front end takes one byte per cycle while the job queue has room.
// Encode throughput is set by the result channel, one character per cycle while
// the receiver is ready; the four divide steps of the next group, a reciprocal
// multiply by 1/85 each, run while the current group is being sent. Decode takes
// one character per cycle while the job queue has room and sends four bytes per
// five characters; a short final group adds one padding step per missing character.
module base85_stream_codec #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   bsc_req_if.sink     req_ch,
   bsc_rsp_if.source   rsp_ch,
   bsc_csr_if.sink     csr_ch
);
   import bsc_pkg::*;

   // front end to queue
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // queue to engine
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // engine to serializer
   logic      grp_valid;
   logic      grp_ready;
   group_type grp;

   // Classify each byte and assemble groups; hold the input while the queue is full.
   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job       (push_job)
   );

   // Decouple intake from conversion so either side can stall alone.
   bsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Turn one group into up to five result bytes.
   bsc_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .grp       (grp)
   );

   // Send the group a byte per transfer; take the next group on the last one.
   bsc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp_ready (grp_ready),
      .grp       (grp),
      .rsp_ch    (rsp_ch)
   );

endmodule

[verif/base85_stream_codec_tb.sv]
// Self-checking testbench for the base85 stream codec: encode and decode, Z85 and Ascii85.
`timescale 1ns / 100ps

module base85_stream_codec_tb;
   import bsc_pkg::*;

   // Timing knobs: idle odds in percent, drain settle time, hold-off, watchdog.
   localparam int IDLE_PCT       = 11;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLDOFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 4000;

   // Index that maps to no register; a write to it must leave everything alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [0:84][7:0] Z85_ALPHABET =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
   localparam logic [7:0] A85_BASE = 8'd33;
   localparam logic [7:0] A85_TOP  = 8'd117;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } codec_in_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } codec_out_type;

   logic clock;
   logic reset;

   bsc_req_if req_ch ();
   bsc_rsp_if rsp_ch ();
   bsc_csr_if csr_ch ();

   base85_stream_codec uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Items waiting for the driver, and bytes/characters the codec still owes us.
   codec_in_type  byte_backlog[$];
   codec_out_type expected_symbols[$];
   int            items_queued   = 0;
   int            items_accepted = 0;
   int            error_count    = 0;

   // Predicted codec state: live configuration plus the partial group.
   logic        cfg_direction = DIR_ENCODE;
   logic        cfg_alphabet  = ALPHA_Z85;
   logic [31:0] grp_value     = '0;
   logic [2:0]  grp_count     = '0;

   // Reverse lookup for Z85: character code to digit, zero for anything else.
   logic [6:0]  z85_digit_of[256];

   // Traffic shaping: quiet mode for both sides, receiver hold-off, watchdog counter.
   bit quiet_mode    = 1'b0;
   bit holdoff_req   = 1'b0;
   bit holdoff_done  = 1'b0;
   int holdoff_count = 0;
   int stall_cycles  = 0;

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Digit <-> character under the active alphabet
   // -------------------------------------------------------------------------
   function automatic logic [7:0] digit_char(input logic [6:0] d);
      if (cfg_alphabet == ALPHA_A85) begin
         return A85_BASE + 8'(d);
      end
      return Z85_ALPHABET[d];
   endfunction

   function automatic logic [6:0] char_digit(input logic [7:0] c);
      if (cfg_alphabet == ALPHA_A85) begin
         return (c >= A85_BASE && c <= A85_TOP) ? 7'(c - A85_BASE) : 7'd0;
      end
      return z85_digit_of[c];
   endfunction

   // -------------------------------------------------------------------------
   // Predictor: fold one accepted transfer into the group, queue what it yields
   // -------------------------------------------------------------------------
   task automatic predict_transfer(input logic [7:0] b, input logic last);
      logic [31:0] v;
      logic [6:0]  dg[5];
      int          emit;
      int          pending;
      if (cfg_direction == DIR_ENCODE) begin
         // Pack big-endian; a short final group stays zero-padded.
         grp_value = grp_value | (32'(b) << (24 - 8 * int'(grp_count[1:0])));
         grp_count = grp_count + 3'd1;
         if (grp_count < ENC_GROUP && !last) begin
            return;
         end
         emit = (grp_count >= ENC_GROUP) ? 5 : int'(grp_count) + 1;
         v = grp_value;
         for (int k = 4; k >= 0; k--) begin
            dg[k] = 7'(v % 32'd85);
            v     = v / 32'd85;
         end
         for (int k = 0; k < emit; k++) begin
            expected_symbols.push_back('{digit_char(dg[k]), last && k == emit - 1});
         end
      end else begin
         // Accumulate mod 2^32; pad a short final group with the top digit.
         grp_value = grp_value * 32'd85 + 32'(char_digit(b));
         grp_count = grp_count + 3'd1;
         if (grp_count < DEC_GROUP && !last) begin
            return;
         end
         pending = int'(grp_count);
         while (grp_count < DEC_GROUP) begin
            grp_value = grp_value * 32'd85 + 32'd84;
            grp_count = grp_count + 3'd1;
         end
         emit = (pending >= 5) ? 4 : pending - 1;
         for (int k = 0; k < emit; k++) begin
            expected_symbols.push_back('{8'(grp_value >> (24 - 8 * k)),
                                         last && k == emit - 1});
         end
      end
      grp_value = '0;
      grp_count = '0;
   endtask

   // -------------------------------------------------------------------------
   // Driver: present backlog items on the request channel
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : byte_feed
      codec_in_type nxt;
      bit           offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         // Account for the transfer that completes at this edge.
         if (req_ch.valid && req_ch.ready) begin
            items_accepted++;
            predict_transfer(req_ch.in_byte, req_ch.in_last);
         end
         // Hold the current item while it waits; otherwise pick the next or idle.
         if (!req_ch.valid || req_ch.ready) begin
            offer = quiet_mode || ($urandom_range(0, 99) >= IDLE_PCT);
            if (offer && byte_backlog.size() != 0) begin
               nxt = byte_backlog.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.in_byte <= nxt.data;
               req_ch.in_last <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check every result transfer, drive ready with stalls
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      codec_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: unexpected result: expected none, got byte %h last %b",
                        $time, rsp_ch.out_byte, rsp_ch.out_last);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_ch.out_byte !== want.code) begin
                  $display("%0t: out_byte mismatch: expected %h, got %h",
                           $time, want.code, rsp_ch.out_byte);
                  error_count++;
               end
               if (rsp_ch.out_last !== want.last) begin
                  $display("%0t: out_last mismatch: expected %b, got %b",
                           $time, want.last, rsp_ch.out_last);
                  error_count++;
               end
            end
         end
         // A requested hold-off keeps ready low, once, until holdoff_count reaches HOLDOFF_CYCLES.
         if (holdoff_req && !holdoff_done) begin
            rsp_ch.ready <= 1'b0;
            holdoff_count++;
            if (holdoff_count >= HOLDOFF_CYCLES) begin
               holdoff_done = 1'b1;
            end
         end else begin
            rsp_ch.ready <= quiet_mode || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: abort when no channel moves a transfer for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   task automatic push_item(input logic [7:0] b, input logic last);
      byte_backlog.push_back('{b, last});
      items_queued++;
   endtask

   // Wait until every item is taken and every result is in, then let the
   // pipeline settle in case the last item only filled a partial group.
   task automatic wait_drained();
      while (items_accepted != items_queued || expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; mirror the effect on the predictor at the transfer.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic val);
      @(posedge clock);
      csr_ch.valid    <= 1'b1;
      csr_ch.wr_index <= idx;
      csr_ch.wr_data  <= {7'($urandom), val};
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_DIRECTION) begin
         cfg_direction = val;
         grp_value     = '0;
         grp_count     = '0;
      end else if (idx == CSR_ALPHABET) begin
         cfg_alphabet = val;
         grp_value    = '0;
         grp_count    = '0;
      end
   endtask

   task automatic queue_fill(input logic [7:0] b, input int n, input bit close);
      @(negedge clock);
      for (int i = 0; i < n; i++) begin
         push_item(b, close && i == n - 1);
      end
   endtask

   task automatic queue_chars(input string s, input bit close);
      @(negedge clock);
      for (int i = 0; i < s.len(); i++) begin
         push_item(s[i], close && i == s.len() - 1);
      end
   endtask

   // One whole message: decode text is mostly legal characters with some noise,
   // encode data leans on the all-zero and all-one bytes now and then.
   task automatic queue_random_message(input bit decoding, input int len);
      logic [7:0] b;
      @(negedge clock);
      for (int i = 0; i < len; i++) begin
         if (decoding) begin
            if ($urandom_range(0, 99) < 85) begin
               b = digit_char(7'($urandom_range(0, 84)));
            end else begin
               b = 8'($urandom_range(0, 255));
            end
         end else begin
            case ($urandom_range(0, 7))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
         end
         push_item(b, i == len - 1);
      end
   endtask

   task automatic run_phase(input logic dir, input logic alpha, input int n_items,
                            input bit stall_receiver);
      int count;
      count = 0;
      wait_drained();
      write_csr(CSR_DIRECTION, dir);
      write_csr(CSR_ALPHABET, alpha);
      if (stall_receiver) begin
         holdoff_req = 1'b1;
      end
      while (count < n_items) begin
         int len;
         len = $urandom_range(1, 13);
         queue_random_message(dir == DIR_DECODE, len);
         count += len;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // Drive every input to a known value before the first edge.
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.in_byte  = '0;
      req_ch.in_last  = 1'b0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.wr_index = '0;
      csr_ch.wr_data  = '0;
      for (int c = 0; c < 256; c++) begin
         z85_digit_of[c] = 7'd0;
      end
      for (int d = 0; d < 85; d++) begin
         z85_digit_of[Z85_ALPHABET[d]] = 7'(d);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: encode with Z85 - all-zero group, all-one group closing the
      // message, then final partial groups of one and three bytes.
      write_csr(CSR_DIRECTION, DIR_ENCODE);
      write_csr(CSR_ALPHABET, ALPHA_Z85);
      queue_fill(8'h00, 4, 1'b0);
      queue_fill(8'hFF, 4, 1'b1);
      queue_fill(8'hAB, 1, 1'b1);
      queue_fill(8'hFF, 1, 1'b0);
      queue_fill(8'h00, 1, 1'b0);
      queue_fill(8'h7F, 1, 1'b1);

      // Leave a partial group behind; the direction write must drop it.
      queue_fill(8'h5A, 1, 1'b0);
      queue_fill(8'hC3, 1, 1'b0);
      wait_drained();
      write_csr(CSR_DIRECTION, DIR_DECODE);
      write_csr(CSR_ALPHABET, ALPHA_A85);

      // Directed: decode with Ascii85. Split a top-digit group around a write
      // to an unmapped index, which must keep the partial group intact.
      queue_chars("uu", 1'b0);
      wait_drained();
      write_csr(CSR_UNMAPPED, 1'b1);
      queue_chars("uuu", 1'b0);
      // Lone final character (also outside the alphabet): nothing comes out.
      queue_chars("z", 1'b1);
      // Four-character final group with characters on both sides of the range.
      queue_chars("v\377 u", 1'b1);

      // Random phases over every direction/alphabet pair; one runs with no
      // idling at all, one starts with a long receiver hold-off.
      run_phase(DIR_ENCODE, ALPHA_Z85, 4, 1'b0);
      wait_drained();
      quiet_mode = 1'b1;
      run_phase(DIR_DECODE, ALPHA_Z85, 20, 1'b0);
      wait_drained();
      quiet_mode = 1'b0;
      run_phase(DIR_ENCODE, ALPHA_A85, 24, 1'b1);
      run_phase(DIR_DECODE, ALPHA_A85, 4, 1'b0);
      run_phase(DIR_ENCODE, ALPHA_Z85, 4, 1'b0);
      run_phase(DIR_DECODE, ALPHA_A85, 4, 1'b0);

      wait_drained();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
